// ===== rtl/bzc_pkg.sv =====
`default_nettype none

package bzc_pkg;

  localparam int OP_W      = 2;
  localparam int STEP_W    = 3;
  localparam int PHASE_W   = 12;
  localparam int TIME_W    = 32;
  localparam int BLANK_W   = 8;
  localparam int CONFIRM_W = 4;
  localparam int PERIOD_W  = 32;
  localparam int CFG_IDX_W = 1;

  localparam int STEP_COUNT = 6;

  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 40;

  localparam logic [BLANK_W-1:0]   BLANK_RESET   = 8'd4;
  localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = 4'd3;
  localparam logic [CONFIRM_W-1:0] CONFIRM_MAX   = 4'd15;
  localparam logic [PERIOD_W-1:0]  US_PER_MS     = 32'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CYCLES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_NEEDED = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE     = 2'd0,
    OP_COMMUTE    = 2'd1,
    OP_BLANK_TICK = 2'd2
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic [STEP_W-1:0]   motor_step;
    logic [PHASE_W-1:0]  phase_a;
    logic [PHASE_W-1:0]  phase_b;
    logic [PHASE_W-1:0]  phase_c;
    logic [TIME_W-1:0]   time_ms;
  } in_beat_t;

  typedef struct packed {
    logic                crossing_found;
    logic                detector_active;
    logic [PERIOD_W-1:0] period_us;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [BLANK_W-1:0]   data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/bzc_core.sv =====
`default_nettype none

module bzc_core #(
  parameter int ADC_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bzc_pkg::cfg_wr_t   cfg,
  input  wire logic               advance,
  input  wire bzc_pkg::in_beat_t  beat,
  output bzc_pkg::result_t        result
);

  localparam int USE_W = (ADC_BITS < bzc_pkg::PHASE_W) ? ADC_BITS : bzc_pkg::PHASE_W;
  localparam int SUM_W = USE_W + 2;

  logic [bzc_pkg::BLANK_W-1:0]   blank_cycles;
  logic [bzc_pkg::CONFIRM_W-1:0] confirm_needed;

  logic [bzc_pkg::BLANK_W-1:0]   blank_left,      blank_left_next;
  logic [bzc_pkg::CONFIRM_W-1:0] confirm_run,     confirm_run_next;
  logic                          detected_flag,   detected_flag_next;
  logic                          expect_rising,   expect_rising_next;
  logic [bzc_pkg::TIME_W-1:0]    last_cross_time, last_cross_time_next;
  logic [bzc_pkg::PERIOD_W-1:0]  period_reg,      period_reg_next;

  logic [USE_W-1:0]              a_u, b_u, c_u, fl;
  logic [SUM_W-1:0]              sum3, fl3;
  logic                          at_or_above, hit;
  logic [bzc_pkg::CONFIRM_W-1:0] run_inc;
  logic [bzc_pkg::TIME_W-1:0]    dt;
  logic [bzc_pkg::PERIOD_W-1:0]  period_raw;
  logic                          found;

  assign a_u = beat.phase_a[USE_W-1:0];
  assign b_u = beat.phase_b[USE_W-1:0];
  assign c_u = beat.phase_c[USE_W-1:0];

  // floating phase by step mod 3: C, B, A
  always_comb begin
    case (beat.motor_step) inside
      3'd0, 3'd3, 3'd6: fl = c_u;
      3'd1, 3'd4, 3'd7: fl = b_u;
      default:          fl = a_u;
    endcase
  end

  // fl >= floor(sum/3)  <=>  sum <= 3*fl + 2
  assign sum3 = {2'b00, a_u} + {2'b00, b_u} + {2'b00, c_u};
  assign fl3  = ({2'b00, fl} << 1) + {2'b00, fl} + SUM_W'(2);
  assign at_or_above = (sum3 <= fl3);
  assign hit = expect_rising ? at_or_above : !at_or_above;

  assign run_inc    = (confirm_run < bzc_pkg::CONFIRM_MAX) ? confirm_run + 1'b1 : confirm_run;
  assign dt         = beat.time_ms - last_cross_time;
  assign period_raw = dt * bzc_pkg::US_PER_MS;

  always_comb begin
    blank_left_next      = blank_left;
    confirm_run_next     = confirm_run;
    detected_flag_next   = detected_flag;
    expect_rising_next   = expect_rising;
    last_cross_time_next = last_cross_time;
    period_reg_next      = period_reg;
    found                = 1'b0;
    case (beat.operation)
      bzc_pkg::OP_SAMPLE: begin
        if (blank_left == '0 && !detected_flag) begin
          if (!hit) begin
            confirm_run_next = '0;
          end else if (run_inc < confirm_needed) begin
            confirm_run_next = run_inc;
          end else begin
            found                = 1'b1;
            confirm_run_next     = '0;
            detected_flag_next   = 1'b1;
            last_cross_time_next = beat.time_ms;
            if (last_cross_time != '0) begin
              period_reg_next = (period_raw == '0) ? bzc_pkg::PERIOD_W'(1) : period_raw;
            end
          end
        end
      end
      bzc_pkg::OP_COMMUTE: begin
        blank_left_next    = blank_cycles;
        confirm_run_next   = '0;
        detected_flag_next = 1'b0;
        // steps 6 and 7 count as step 0
        expect_rising_next = beat.motor_step[0] && (beat.motor_step != 3'd7);
      end
      bzc_pkg::OP_BLANK_TICK: begin
        if (blank_left != '0) begin
          blank_left_next = blank_left - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.crossing_found  = found;
  assign result.detector_active = (blank_left_next == '0);
  assign result.period_us       = period_reg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_cycles    <= bzc_pkg::BLANK_RESET;
      confirm_needed  <= bzc_pkg::CONFIRM_RESET;
      blank_left      <= bzc_pkg::BLANK_RESET;
      confirm_run     <= '0;
      detected_flag   <= 1'b0;
      expect_rising   <= 1'b0;
      last_cross_time <= '0;
      period_reg      <= '0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          bzc_pkg::CFG_BLANK_CYCLES:   blank_cycles   <= cfg.data;
          bzc_pkg::CFG_CONFIRM_NEEDED: confirm_needed <= cfg.data[bzc_pkg::CONFIRM_W-1:0];
        endcase
      end
      if (advance) begin
        blank_left      <= blank_left_next;
        confirm_run     <= confirm_run_next;
        detected_flag   <= detected_flag_next;
        expect_rising   <= expect_rising_next;
        last_cross_time <= last_cross_time_next;
        period_reg      <= period_reg_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bemf_zero_crossing_detector.sv =====
// Back-EMF zero-crossing qualifier for a sensorless six-step drive.
// Input stream: one beat per item. s_tuser carries the operation (sample,
// commutation, blank tick); s_tdata carries step, three phase ADC counts and
// a millisecond timestamp. Output stream: exactly one beat per input beat,
// in order, with crossing flag, blank-done status and the last period in us.
// Configuration: cfg_we/cfg_index/cfg_data write blank_cycles (index 0) or
// confirm_needed (index 1); write only while the stream is idle.
// Path: an accepted beat passes the input register, then the result
// register, to m_tvalid. Throughput: one beat per cycle while m_tready is
// high; the whole qualifier update (neutral compare, hit count, period
// multiply by 1000) completes between the input and result registers.
// Reset (rst, synchronous): both stages empty, registers back to
// blank_cycles 4 and confirm_needed 3, blanking armed, period zero.
// Stall: while m_tready is low a result is held; one more beat is still
// taken into the input register, after which s_tready drops.
`default_nettype none

module bemf_zero_crossing_detector #(
  parameter int ADC_BITS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [bzc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bzc_pkg::BLANK_W-1:0]       cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [2:0] motor_step, [14:3] phase_a, [26:15] phase_b, [38:27] phase_c,
  // [70:39] time_ms, [71] zero
  input  wire logic [bzc_pkg::S_TDATA_W-1:0]     s_tdata,
  // [1:0] operation
  input  wire logic [bzc_pkg::OP_W-1:0]          s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [0] crossing_found, [1] detector_active, [33:2] period_us, [39:34] zero
  output logic [bzc_pkg::M_TDATA_W-1:0]          m_tdata
);

  logic              in_valid;
  bzc_pkg::in_beat_t in_beat;
  bzc_pkg::in_beat_t s_beat;
  logic              out_valid;
  bzc_pkg::result_t  out_beat;
  bzc_pkg::result_t  res;
  bzc_pkg::cfg_wr_t  cfg;
  logic              advance;

  assign s_beat.operation  = bzc_pkg::op_t'(s_tuser);
  assign s_beat.motor_step = s_tdata[2:0];
  assign s_beat.phase_a    = s_tdata[14:3];
  assign s_beat.phase_b    = s_tdata[26:15];
  assign s_beat.phase_c    = s_tdata[38:27];
  assign s_beat.time_ms    = s_tdata[70:39];

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  bzc_core #(
    .ADC_BITS (ADC_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .beat    (in_beat),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (s_tvalid && s_tready) begin
      in_beat <= s_beat;
    end
    if (advance) begin
      out_beat <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_beat.period_us, out_beat.detector_active,
                     out_beat.crossing_found};

`ifndef NO_ASSERTIONS
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  a_crossing_when_active: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> m_tdata[1])
    else $error("crossing reported while blanking");

  a_empty_output_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !m_tvalid) |=> m_tvalid)
    else $error("pending beat did not reach output register");
`endif

endmodule

`default_nettype wire
